### sv/mlp_pkg.sv
// Package for the message latency percentile unit.
// Holds sizing constants, register indexes, status codes and the state type.
// No dependencies.
package mlp_pkg;

  localparam int MAX_SAMPLES_DEF       = 1024;
  localparam int MAX_MESSAGE_BYTES_DEF = 4096;
  localparam int MIN_MESSAGE_BYTES     = 16;
  localparam int STAMP_FIRST           = 8;
  localparam int STAMP_LAST            = 15;
  localparam int LAT_W                 = 64;
  localparam int CNT_W                 = 11;
  localparam int SIZE_W                = 13;
  localparam int CFG_IDX_W             = 1;
  localparam int STATUS_W              = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE     = 1'b1;

  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_OUTER,
    S_RDJ,
    S_CMP,
    S_PICK,
    S_PRD,
    S_PCAP,
    S_DONE
  } state_t;

endpackage

### sv/message_latency_percentiles_unit.sv
// Top level of the message latency percentile unit.
// Collects per-message latencies into a store, sorts them and reports.
// Depends on mlp_pkg.
//
// Usage:
//   in_* channel: one beat per stream byte (in_cmd 0) or an end beat (in_cmd 1).
//   Byte beats are taken one per cycle while in_ready is high. A beat that
//   completes a message writes one latency into the store.
//   A report starts on an end beat or when the expected count is reached.
//   The store is then insertion-sorted by one shared 64-bit compare unit
//   and one memory read port plus one write port (states S_OUTER, S_RDJ,
//   S_CMP), then six percentile reads follow (states S_PICK, S_PRD, S_PCAP).
//   in_ready is low from the report beat until the result leaves.
//   out_* channel: one result beat per report, held in an output register
//   until out_ready. The receiver may stall freely; input stays blocked.
//   cfg_* channel: always ready; index 0 expected_count, 1 message_size.
//   Reset (rst_n low, synchronous) clears the registers to 1024 and 64,
//   empties the run and drops any pending result. The store needs no clear.
module message_latency_percentiles_unit #(
  parameter int MAX_SAMPLES       = mlp_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_MESSAGE_BYTES = mlp_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [7:0]                          in_data_byte,
  input  logic [mlp_pkg::LAT_W-1:0]           in_time_now,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mlp_pkg::CNT_W-1:0]           out_received_count,
  output logic [mlp_pkg::LAT_W-1:0]           out_latency_min,
  output logic [mlp_pkg::LAT_W-1:0]           out_latency_p50,
  output logic [mlp_pkg::LAT_W-1:0]           out_latency_p90,
  output logic [mlp_pkg::LAT_W-1:0]           out_latency_p99,
  output logic [mlp_pkg::LAT_W-1:0]           out_latency_p999,
  output logic [mlp_pkg::LAT_W-1:0]           out_latency_max,
  output logic [mlp_pkg::STATUS_W-1:0]        out_run_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mlp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mlp_pkg::SIZE_W-1:0]          cfg_data
);
  import mlp_pkg::*;

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int NW  = $clog2(MAX_SAMPLES + 1);
  localparam int OW  = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int XW  = NW + 10;
  localparam int RS  = 36;
  localparam logic [33:0] RCP10   = 34'd6871947674;
  localparam logic [33:0] RCP100  = 34'd687194768;
  localparam logic [33:0] RCP1000 = 34'd68719477;

  logic [CNT_W-1:0]  exp_cfg_r;
  logic [SIZE_W-1:0] size_cfg_r;
  logic [OW-1:0]     offset_r;
  logic [LAT_W-1:0]  stamp_r;
  logic [NW-1:0]     coll_r;
  state_t            state_r, state_nxt;
  logic [NW-1:0]     i_r, j_r;
  logic [LAT_W-1:0]  v_r, rd_r;
  logic [2:0]        pk_r;
  logic [LAT_W-1:0]  res_r [6];
  logic [NW-1:0]     n_r;
  logic [STATUS_W-1:0] st_r;
  logic              ov_r;
  logic [LAT_W-1:0]  mem [MAX_SAMPLES];

  logic [NW-1:0]  eff_exp;
  logic [OW-1:0]  eff_size;
  logic           acc, byte_acc, msg_end, store_wr, full_after;
  logic [NW-1:0]  coll_inc;
  logic [LAT_W-1:0] stamp_nxt;
  logic           mem_we;
  logic [AW-1:0]  mem_wa, mem_ra;
  logic [LAT_W-1:0] mem_wd;
  logic [NW-1:0]  pidx;
  logic [XW-1:0]  xk;
  logic [33:0]    rcp;
  logic [XW+33:0] pm;

  always_comb begin
    if (exp_cfg_r == '0) eff_exp = NW'(1);
    else if (32'(exp_cfg_r) > MAX_SAMPLES) eff_exp = NW'(MAX_SAMPLES);
    else eff_exp = NW'(exp_cfg_r);
    if (32'(size_cfg_r) < MIN_MESSAGE_BYTES) eff_size = OW'(MIN_MESSAGE_BYTES);
    else if (32'(size_cfg_r) > MAX_MESSAGE_BYTES) eff_size = OW'(MAX_MESSAGE_BYTES);
    else eff_size = OW'(size_cfg_r);
  end

  assign in_ready  = (state_r == S_COLLECT) && !ov_r;
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;
  assign byte_acc  = acc && !in_cmd;

  always_comb begin
    stamp_nxt = stamp_r;
    if (32'(offset_r) >= STAMP_FIRST && 32'(offset_r) <= STAMP_LAST)
      stamp_nxt[8*offset_r[2:0] +: 8] = in_data_byte;
  end

  assign msg_end    = (32'(offset_r) + 1) >= 32'(eff_size);
  assign store_wr   = byte_acc && msg_end && (32'(coll_r) < MAX_SAMPLES);
  assign coll_inc   = store_wr ? coll_r + NW'(1) : coll_r;
  assign full_after = byte_acc && msg_end && (coll_inc >= eff_exp);

  always_comb begin
    xk  = '0;
    rcp = '0;
    unique case (pk_r)
      3'd2: begin
        xk = XW'(n_r) * XW'(9);    rcp = RCP10;
      end
      3'd3: begin
        xk = XW'(n_r) * XW'(99);   rcp = RCP100;
      end
      3'd4: begin
        xk = XW'(n_r) * XW'(999);  rcp = RCP1000;
      end
      default: ;
    endcase
    pm = (XW+34)'(xk) * (XW+34)'(rcp);
    unique case (pk_r)
      3'd0:                pidx = '0;
      3'd1:                pidx = n_r >> 1;
      3'd2, 3'd3, 3'd4:    pidx = NW'(pm >> RS);
      default:             pidx = n_r - NW'(1);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_COLLECT: if ((acc && in_cmd) || full_after) state_nxt = S_OUTER;
      S_OUTER: begin
        if (n_r == '0) state_nxt = S_DONE;
        else if (i_r >= n_r) state_nxt = S_PICK;
        else state_nxt = S_RDJ;
      end
      S_RDJ:   state_nxt = (j_r == '0) ? S_OUTER : S_CMP;
      S_CMP:   state_nxt = (rd_r > v_r) ? S_RDJ : S_OUTER;
      S_PICK:  state_nxt = (pk_r == 3'd6) ? S_DONE : S_PRD;
      S_PRD:   state_nxt = S_PCAP;
      S_PCAP:  state_nxt = S_PICK;
      S_DONE:  state_nxt = S_COLLECT;
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = coll_r[AW-1:0];
    mem_wd = in_time_now - stamp_nxt;
    mem_ra = i_r[AW-1:0];
    unique case (state_r)
      S_COLLECT: mem_we = store_wr;
      S_OUTER:   mem_ra = i_r[AW-1:0];
      S_RDJ: begin
        mem_ra = AW'(j_r - NW'(1));
        if (j_r == '0) begin
          mem_we = 1'b1; mem_wa = '0; mem_wd = v_r;
        end
      end
      S_CMP: begin
        mem_we = 1'b1;
        mem_wa = j_r[AW-1:0];
        mem_wd = (rd_r > v_r) ? rd_r : v_r;
      end
      S_PRD:   mem_ra = pidx[AW-1:0];
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cfg_r  <= CNT_W'(1024);
      size_cfg_r <= SIZE_W'(64);
      offset_r   <= '0;
      stamp_r    <= '0;
      coll_r     <= '0;
      state_r    <= S_COLLECT;
      ov_r       <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
      pk_r       <= '0;
      n_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == REG_EXPECTED) exp_cfg_r <= CNT_W'(cfg_data);
        if (cfg_index == REG_SIZE)     size_cfg_r <= cfg_data;
      end
      if (out_valid && out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_COLLECT: begin
          if (byte_acc) begin
            stamp_r  <= stamp_nxt;
            coll_r   <= coll_inc;
            offset_r <= msg_end ? '0 : offset_r + OW'(1);
          end
          if ((acc && in_cmd) || full_after) begin
            n_r  <= (acc && in_cmd) ? coll_r : coll_inc;
            i_r  <= NW'(1);
            pk_r <= '0;
          end
        end
        S_OUTER: begin
          j_r <= i_r;
        end
        S_RDJ: begin
          if (j_r == i_r) v_r <= rd_r;
        end
        S_CMP: begin
          if (rd_r > v_r) j_r <= j_r - NW'(1);
          else i_r <= i_r + NW'(1);
        end
        S_PICK: ;
        S_PRD: ;
        S_PCAP: begin
          res_r[pk_r] <= rd_r;
          pk_r <= pk_r + 3'd1;
        end
        S_DONE: begin
          ov_r     <= 1'b1;
          offset_r <= '0;
          stamp_r  <= '0;
          coll_r   <= '0;
          st_r     <= (n_r == '0) ? ST_NONE : ((n_r >= eff_exp) ? ST_FULL : ST_SHORT);
        end
        default: ;
      endcase
      if (state_r == S_RDJ && j_r == '0) i_r <= i_r + NW'(1);
    end
  end

  logic nz;
  assign nz = (st_r != ST_NONE);
  assign out_valid          = ov_r;
  assign out_received_count = CNT_W'(n_r);
  assign out_latency_min    = nz ? res_r[0] : '0;
  assign out_latency_p50    = nz ? res_r[1] : '0;
  assign out_latency_p90    = nz ? res_r[2] : '0;
  assign out_latency_p99    = nz ? res_r[3] : '0;
  assign out_latency_p999   = nz ? res_r[4] : '0;
  assign out_latency_max    = nz ? res_r[5] : '0;
  assign out_run_status     = st_r;

endmodule

### tb/tb.sv
// Testbench for message_latency_percentiles_unit: byte-stream messages with random
// stamps, timing and register settings; reports checked against an in-bench predictor.
// Depends on mlp_pkg and the unit's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlp_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam int SETTLE = 40;

  typedef struct {
    logic [CNT_W-1:0]    cnt;
    logic [LAT_W-1:0]    mn, p50, p90, p99, p999, mx;
    logic [STATUS_W-1:0] status;
  } report_t;

  class latency_scoreboard;
    logic [CNT_W-1:0]  exp_reg;
    logic [SIZE_W-1:0] size_reg;
    int                byte_off;
    logic [LAT_W-1:0]  stamp;
    int                collected;
    logic [LAT_W-1:0]  lat_store[MAX_SAMPLES_DEF];
    report_t           pending[$];
    int                errors;

    function void reset_state();
      exp_reg = 11'd1024;
      size_reg = 13'd64;
      byte_off = 0;
      stamp = '0;
      collected = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] d);
      if (idx == REG_EXPECTED) exp_reg = d[CNT_W-1:0];
      else size_reg = d;
    endfunction

    function int eff_expected();
      int e;
      e = int'(exp_reg);
      if (e < 1) e = 1;
      if (e > MAX_SAMPLES_DEF) e = MAX_SAMPLES_DEF;
      return e;
    endfunction

    function int eff_size();
      int s;
      s = int'(size_reg);
      if (s < MIN_MESSAGE_BYTES) s = MIN_MESSAGE_BYTES;
      if (s > MAX_MESSAGE_BYTES_DEF) s = MAX_MESSAGE_BYTES_DEF;
      return s;
    endfunction

    function void queue_report();
      logic [LAT_W-1:0] s[$];
      report_t r;
      int n;
      n = collected;
      r.cnt = n[CNT_W-1:0];
      r.mn = '0; r.p50 = '0; r.p90 = '0; r.p99 = '0; r.p999 = '0; r.mx = '0;
      if (n == 0) begin
        r.status = ST_NONE;
      end else begin
        for (int i = 0; i < n; i++) s.push_back(lat_store[i]);
        s.sort();
        r.mn = s[0];
        r.p50 = s[(n * 50) / 100];
        r.p90 = s[(n * 90) / 100];
        r.p99 = s[(n * 99) / 100];
        r.p999 = s[(n * 999) / 1000];
        r.mx = s[n - 1];
        r.status = (n >= eff_expected()) ? ST_FULL : ST_SHORT;
      end
      pending.push_back(r);
      byte_off = 0;
      stamp = '0;
      collected = 0;
    endfunction

    function void note_beat(logic cmd, logic [7:0] b, logic [LAT_W-1:0] now);
      int size;
      size = eff_size();
      if (cmd) begin
        queue_report();
        return;
      end
      if (byte_off >= STAMP_FIRST && byte_off <= STAMP_LAST)
        stamp[(byte_off - STAMP_FIRST) * 8 +: 8] = b;
      if (byte_off + 1 >= size) begin
        if (collected < MAX_SAMPLES_DEF) begin
          lat_store[collected] = now - stamp;
          collected++;
        end
        byte_off = 0;
        if (collected >= eff_expected()) queue_report();
      end else begin
        byte_off++;
      end
    endfunction

    function void check(report_t got);
      report_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: report with none pending, count %0d", got.cnt);
        return;
      end
      w = pending.pop_front();
      if (got.cnt !== w.cnt || got.mn !== w.mn || got.p50 !== w.p50 || got.p90 !== w.p90 ||
          got.p99 !== w.p99 || got.p999 !== w.p999 || got.mx !== w.mx ||
          got.status !== w.status) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: count exp %0d got %0d, status exp %0d got %0d",
                   w.cnt, got.cnt, w.status, got.status);
          $display("  min %0h/%0h p50 %0h/%0h p90 %0h/%0h", w.mn, got.mn, w.p50, got.p50,
                   w.p90, got.p90);
          $display("  p99 %0h/%0h p999 %0h/%0h max %0h/%0h", w.p99, got.p99, w.p999, got.p999,
                   w.mx, got.mx);
        end
      end
    endfunction
  endclass

  logic                 clk, rst_n;
  logic                 in_valid, in_ready, in_cmd;
  logic [7:0]           in_data_byte;
  logic [LAT_W-1:0]     in_time_now;
  logic                 out_valid, out_ready;
  logic [CNT_W-1:0]     out_received_count;
  logic [LAT_W-1:0]     out_latency_min, out_latency_p50, out_latency_p90;
  logic [LAT_W-1:0]     out_latency_p99, out_latency_p999, out_latency_max;
  logic [STATUS_W-1:0]  out_run_status;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  latency_scoreboard sb;
  logic [LAT_W-1:0]  clock_ns;
  int                burst_left;
  int                beats_sent;
  int                idle_cycles;
  int                stall_mode, stall_left;

  message_latency_percentiles_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_beat(in_cmd, in_data_byte, in_time_now);
    if (rst_n && cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    if (rst_n && out_valid && out_ready)
      sb.check('{out_received_count, out_latency_min, out_latency_p50, out_latency_p90,
                 out_latency_p99, out_latency_p999, out_latency_max, out_run_status});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("message_latency_percentiles_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: alternate between always ready, random stalls and long stalls
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready = 1'b1;
      1: out_ready = ($urandom_range(0, 3) != 0);
      default: out_ready = ($urandom_range(0, 15) == 0);
    endcase
  end

  task automatic hold_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
    end
  endtask

  task automatic send_beat(logic cmd, logic [7:0] b, logic [LAT_W-1:0] now);
    in_valid = 1'b1;
    in_cmd = cmd;
    in_data_byte = b;
    in_time_now = now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
    hold_gap();
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] d);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic advance_clock();
    if ($urandom_range(0, 63) == 0) clock_ns = {$urandom, $urandom};
    else clock_ns = clock_ns + 64'($urandom_range(0, 500));
  endtask

  // send nbytes of a message whose stamp is the given value
  task automatic send_message(logic [LAT_W-1:0] st, int nbytes);
    for (int o = 0; o < nbytes; o++) begin
      advance_clock();
      if (o >= STAMP_FIRST && o <= STAMP_LAST)
        send_beat(1'b0, st[(o - STAMP_FIRST) * 8 +: 8], clock_ns);
      else
        send_beat(1'b0, 8'($urandom_range(0, 255)), clock_ns);
    end
  endtask

  function automatic logic [LAT_W-1:0] pick_stamp();
    logic [LAT_W-1:0] lat;
    case ($urandom_range(0, 5))
      0: lat = {$urandom, $urandom};
      1: lat = 64'($urandom_range(0, 3));
      default: lat = 64'($urandom_range(0, 100000));
    endcase
    return clock_ns - lat;
  endfunction

  task automatic send_end();
    advance_clock();
    send_beat(1'b1, 8'($urandom_range(0, 255)), clock_ns);
  endtask

  initial begin
    int exp_n, size_n, msgs;
    sb = new();
    sb.reset_state();
    rst_n = 1'b0;
    in_valid = 1'b0; in_cmd = 1'b0; in_data_byte = '0; in_time_now = '0;
    cfg_valid = 1'b0; cfg_index = REG_EXPECTED; cfg_data = '0;
    burst_left = 0; beats_sent = 0;
    clock_ns = 64'd1000;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // end with nothing collected, then a partial message discarded by an end
    send_end();
    send_message(pick_stamp(), 5);
    send_end();

    // clamped low registers: every 16-byte message reports alone
    write_reg(REG_EXPECTED, 13'd0);
    write_reg(REG_SIZE, 13'd0);
    send_message(64'd0, 16);
    clock_ns = '1;
    send_message(64'hFFFF_FFFF_FFFF_FFFF, 16);
    send_message(64'd5, 16);
    clock_ns = 64'd0;
    send_message(64'hFFFF_FFFF_FFFF_FFFF, 16);

    // short run, full run, end right after the count was met
    write_reg(REG_EXPECTED, 13'd3);
    write_reg(REG_SIZE, 13'd15);
    clock_ns = 64'h0123_4567_89AB_CDEF;
    send_message(pick_stamp(), 16);
    send_message(clock_ns + 64'd7, 16);
    send_end();
    for (int i = 0; i < 3; i++) send_message(pick_stamp(), 16);
    send_end();

    // shrink the size and the expected count in the middle of a message
    write_reg(REG_EXPECTED, 13'd5);
    write_reg(REG_SIZE, 13'd32);
    for (int i = 0; i < 3; i++) send_message(pick_stamp(), 32);
    send_message(pick_stamp(), 20);
    write_reg(REG_SIZE, 13'd16);
    write_reg(REG_EXPECTED, 13'd2);
    send_message(pick_stamp(), 1);

    // largest size and count, both written above range
    write_reg(REG_EXPECTED, 13'd2047);
    write_reg(REG_SIZE, 13'h1FFF);
    send_message(pick_stamp(), 100);
    send_end();
    write_reg(REG_EXPECTED, 13'd1024);
    write_reg(REG_SIZE, 13'd4096);
    send_message(pick_stamp(), 17);
    send_end();

    while (beats_sent < 1400) begin
      exp_n = $urandom_range(0, 7) == 0 ? $urandom_range(9, 40) : $urandom_range(0, 8);
      case ($urandom_range(0, 7))
        0: size_n = $urandom_range(0, 15);
        1: size_n = $urandom_range(17, 48);
        default: size_n = 16;
      endcase
      if ($urandom_range(0, 1)) write_reg(REG_EXPECTED, SIZE_W'(exp_n));
      if ($urandom_range(0, 1)) write_reg(REG_SIZE, SIZE_W'(size_n));
      msgs = $urandom_range(1, 12);
      for (int m = 0; m < msgs; m++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_message(pick_stamp(), $urandom_range(1, 20));
          send_end();
        end else begin
          send_message(pick_stamp(), sb.eff_size() - sb.byte_off);
        end
      end
      if ($urandom_range(0, 3) == 0) send_end();
      if ($urandom_range(0, 5) == 0) drain();
    end

    drain();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("message_latency_percentiles_unit test passed");
    end else begin
      $display("message_latency_percentiles_unit test failed");
    end
    $finish;
  end
endmodule
